// ===== design/scrc_pkg.sv =====
package scrc_pkg;

  // input commands
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_FAULT = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  localparam logic [1:0] FAULT_TIMEOUT = 2'd0;

  // handshake phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_METHOD = 3'd1;
  localparam logic [2:0] PH_AUTH   = 3'd2;
  localparam logic [2:0] PH_HEADER = 3'd3;
  localparam logic [2:0] PH_DLEN   = 3'd4;
  localparam logic [2:0] PH_ADDR   = 3'd5;
  localparam logic [2:0] PH_PORT   = 3'd6;
  localparam logic [2:0] PH_DONE   = 3'd7;

  // reported status
  localparam logic [2:0] ST_WAIT    = 3'd0;
  localparam logic [2:0] ST_AUTH    = 3'd1;
  localparam logic [2:0] ST_CONNECT = 3'd2;
  localparam logic [2:0] ST_OK      = 3'd3;
  localparam logic [2:0] ST_FAIL    = 3'd4;

  // error codes
  localparam logic [3:0] ERR_NONE        = 4'd0;
  localparam logic [3:0] ERR_GREET_RX    = 4'd1;
  localparam logic [3:0] ERR_GREET_VER   = 4'd2;
  localparam logic [3:0] ERR_BAD_METHOD  = 4'd3;
  localparam logic [3:0] ERR_AUTH_RX     = 4'd4;
  localparam logic [3:0] ERR_AUTH_REJECT = 4'd5;
  localparam logic [3:0] ERR_REPLY_TMO   = 4'd6;
  localparam logic [3:0] ERR_REPLY_RX    = 4'd7;
  localparam logic [3:0] ERR_REPLY_VER   = 4'd8;
  localparam logic [3:0] ERR_NOT_SUCC    = 4'd9;
  localparam logic [3:0] ERR_RSV_ATYP    = 4'd10;
  localparam logic [3:0] ERR_ADDR_RX     = 4'd11;

  // protocol bytes
  localparam logic [7:0] SOCKS_VER      = 8'h05;
  localparam logic [7:0] AUTH_VER       = 8'h01;
  localparam logic [7:0] METHOD_NONE    = 8'h00;
  localparam logic [7:0] METHOD_USERPW  = 8'h02;
  localparam logic [7:0] REP_SUCCEEDED  = 8'h00;
  localparam logic [7:0] AUTH_OK        = 8'h00;
  localparam logic [7:0] ATYP_IPV4      = 8'h01;
  localparam logic [7:0] ATYP_DOMAIN    = 8'h03;
  localparam logic [7:0] ATYP_IPV6      = 8'h04;
  localparam logic [7:0] IPV4_LEN       = 8'd4;
  localparam logic [7:0] IPV6_LEN       = 8'd16;

  typedef struct packed {
    logic [2:0]  phase;
    logic [1:0]  byte_index;
    logic [7:0]  skip_count;
    logic [23:0] header_hold;
    logic [2:0]  final_status;
    logic [3:0]  final_error;
  } state_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] error_code;
    logic [7:0] reply_code;
  } result_t;

  localparam state_t STATE_RESET = '{
    phase:        PH_IDLE,
    byte_index:   2'd0,
    skip_count:   8'd0,
    header_hold:  24'd0,
    final_status: ST_WAIT,
    final_error:  ERR_NONE
  };

endpackage

// ===== design/scrc_if.sv =====
interface scrc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] rx_byte;
  logic [1:0] fault_kind;

  modport source (output valid, cmd, rx_byte, fault_kind, input ready);
  modport sink   (input valid, cmd, rx_byte, fault_kind, output ready);
endinterface

interface scrc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [3:0] error_code;
  logic [7:0] reply_code;

  modport source (output valid, status, error_code, reply_code, input ready);
  modport sink   (input valid, status, error_code, reply_code, output ready);
endinterface

// ===== design/scrc_step.sv =====
// One handshake step: next state and result for one input word.
module scrc_step (
  input  scrc_pkg::state_t  st,
  input  logic              auth_offered,
  input  logic [1:0]        cmd,
  input  logic [7:0]        rx_byte,
  input  logic [1:0]        fault_kind,
  output scrc_pkg::state_t  st_nxt,
  output scrc_pkg::result_t res
);

  logic [2:0] emit_status;
  logic [7:0] skip_dec;

  assign skip_dec = st.skip_count - 8'd1;

  always_comb begin
    st_nxt      = st;
    emit_status = scrc_pkg::ST_WAIT;

    unique case (cmd)
      scrc_pkg::CMD_START: begin
        st_nxt       = scrc_pkg::STATE_RESET;
        st_nxt.phase = scrc_pkg::PH_METHOD;
      end
      scrc_pkg::CMD_BYTE: begin
        unique case (st.phase)
          scrc_pkg::PH_METHOD: begin
            if (st.byte_index == 2'd0) begin
              st_nxt.header_hold = {16'd0, rx_byte};
              st_nxt.byte_index  = 2'd1;
            end else if (st.header_hold[7:0] != scrc_pkg::SOCKS_VER) begin
              st_nxt.phase       = scrc_pkg::PH_DONE;
              st_nxt.final_status = scrc_pkg::ST_FAIL;
              st_nxt.final_error = scrc_pkg::ERR_GREET_VER;
            end else if (rx_byte == scrc_pkg::METHOD_USERPW && auth_offered) begin
              st_nxt.phase      = scrc_pkg::PH_AUTH;
              st_nxt.byte_index = 2'd0;
              emit_status       = scrc_pkg::ST_AUTH;
            end else if (rx_byte == scrc_pkg::METHOD_NONE) begin
              st_nxt.phase      = scrc_pkg::PH_HEADER;
              st_nxt.byte_index = 2'd0;
              emit_status       = scrc_pkg::ST_CONNECT;
            end else begin
              st_nxt.phase        = scrc_pkg::PH_DONE;
              st_nxt.final_status = scrc_pkg::ST_FAIL;
              st_nxt.final_error  = scrc_pkg::ERR_BAD_METHOD;
            end
          end
          scrc_pkg::PH_AUTH: begin
            if (st.byte_index == 2'd0) begin
              st_nxt.header_hold = {16'd0, rx_byte};
              st_nxt.byte_index  = 2'd1;
            end else if (st.header_hold[7:0] != scrc_pkg::AUTH_VER ||
                         rx_byte != scrc_pkg::AUTH_OK) begin
              st_nxt.phase        = scrc_pkg::PH_DONE;
              st_nxt.final_status = scrc_pkg::ST_FAIL;
              st_nxt.final_error  = scrc_pkg::ERR_AUTH_REJECT;
            end else begin
              st_nxt.phase      = scrc_pkg::PH_HEADER;
              st_nxt.byte_index = 2'd0;
              emit_status       = scrc_pkg::ST_CONNECT;
            end
          end
          scrc_pkg::PH_HEADER: begin
            priority if (st.byte_index == 2'd0) begin
              st_nxt.header_hold = {16'd0, rx_byte};
              st_nxt.byte_index  = 2'd1;
            end else if (st.byte_index == 2'd1) begin
              st_nxt.header_hold[15:8] = rx_byte;
              st_nxt.byte_index        = 2'd2;
            end else if (st.byte_index == 2'd2) begin
              st_nxt.header_hold[23:16] = rx_byte;
              st_nxt.byte_index         = 2'd3;
            end else if (st.header_hold[7:0] != scrc_pkg::SOCKS_VER) begin
              st_nxt.phase        = scrc_pkg::PH_DONE;
              st_nxt.final_status = scrc_pkg::ST_FAIL;
              st_nxt.final_error  = scrc_pkg::ERR_REPLY_VER;
            end else if (st.header_hold[15:8] != scrc_pkg::REP_SUCCEEDED) begin
              st_nxt.phase        = scrc_pkg::PH_DONE;
              st_nxt.final_status = scrc_pkg::ST_FAIL;
              st_nxt.final_error  = scrc_pkg::ERR_NOT_SUCC;
            end else if (st.header_hold[23:16] != 8'd0) begin
              st_nxt.phase        = scrc_pkg::PH_DONE;
              st_nxt.final_status = scrc_pkg::ST_FAIL;
              st_nxt.final_error  = scrc_pkg::ERR_RSV_ATYP;
            end else if (rx_byte == scrc_pkg::ATYP_IPV4 ||
                         rx_byte == scrc_pkg::ATYP_IPV6) begin
              st_nxt.phase      = scrc_pkg::PH_ADDR;
              st_nxt.byte_index = 2'd0;
              st_nxt.skip_count = (rx_byte == scrc_pkg::ATYP_IPV4) ?
                                  scrc_pkg::IPV4_LEN : scrc_pkg::IPV6_LEN;
            end else if (rx_byte == scrc_pkg::ATYP_DOMAIN) begin
              st_nxt.phase      = scrc_pkg::PH_DLEN;
              st_nxt.byte_index = 2'd0;
            end else begin
              st_nxt.phase        = scrc_pkg::PH_DONE;
              st_nxt.final_status = scrc_pkg::ST_FAIL;
              st_nxt.final_error  = scrc_pkg::ERR_RSV_ATYP;
            end
          end
          scrc_pkg::PH_DLEN: begin
            st_nxt.skip_count = rx_byte;
            st_nxt.byte_index = 2'd0;
            st_nxt.phase      = (rx_byte == 8'd0) ? scrc_pkg::PH_PORT : scrc_pkg::PH_ADDR;
          end
          scrc_pkg::PH_ADDR: begin
            st_nxt.skip_count = skip_dec;
            if (skip_dec == 8'd0) begin
              st_nxt.phase      = scrc_pkg::PH_PORT;
              st_nxt.byte_index = 2'd0;
            end
          end
          scrc_pkg::PH_PORT: begin
            if (st.byte_index == 2'd0) begin
              st_nxt.byte_index = 2'd1;
            end else begin
              st_nxt.phase        = scrc_pkg::PH_DONE;
              st_nxt.final_status = scrc_pkg::ST_OK;
              st_nxt.final_error  = scrc_pkg::ERR_NONE;
            end
          end
          default: begin
            // idle or done: byte ignored
          end
        endcase
      end
      scrc_pkg::CMD_FAULT: begin
        unique case (st.phase)
          scrc_pkg::PH_METHOD: begin
            st_nxt.phase        = scrc_pkg::PH_DONE;
            st_nxt.final_status = scrc_pkg::ST_FAIL;
            st_nxt.final_error  = scrc_pkg::ERR_GREET_RX;
          end
          scrc_pkg::PH_AUTH: begin
            st_nxt.phase        = scrc_pkg::PH_DONE;
            st_nxt.final_status = scrc_pkg::ST_FAIL;
            st_nxt.final_error  = scrc_pkg::ERR_AUTH_RX;
          end
          scrc_pkg::PH_HEADER: begin
            st_nxt.phase        = scrc_pkg::PH_DONE;
            st_nxt.final_status = scrc_pkg::ST_FAIL;
            st_nxt.final_error  = (fault_kind == scrc_pkg::FAULT_TIMEOUT) ?
                                  scrc_pkg::ERR_REPLY_TMO : scrc_pkg::ERR_REPLY_RX;
          end
          scrc_pkg::PH_DLEN, scrc_pkg::PH_ADDR, scrc_pkg::PH_PORT: begin
            st_nxt.phase        = scrc_pkg::PH_DONE;
            st_nxt.final_status = scrc_pkg::ST_FAIL;
            st_nxt.final_error  = scrc_pkg::ERR_ADDR_RX;
          end
          default: begin
            // idle or done: fault ignored
          end
        endcase
      end
      scrc_pkg::CMD_NOP: begin
      end
      default: begin
      end
    endcase
  end

  // done phase echoes the outcome; otherwise report the step's own status
  always_comb begin
    if (st_nxt.phase == scrc_pkg::PH_DONE) begin
      res.status     = st_nxt.final_status;
      res.error_code = st_nxt.final_error;
      res.reply_code = (st_nxt.final_error == scrc_pkg::ERR_NOT_SUCC) ?
                       st_nxt.header_hold[15:8] : 8'd0;
    end else begin
      res.status     = emit_status;
      res.error_code = scrc_pkg::ERR_NONE;
      res.reply_code = 8'd0;
    end
  end

endmodule

// ===== design/socks5_client_reply_checker.sv =====
// Path: an accepted word is held in the input register, then its result in the result register.
// Throughput: one word per cycle; the input and result registers are both
// held only while the result side stalls.
// Reset: rst_n is synchronous, active low; it clears the handshake state to
// idle, the auth_offered register to 0 and both valid flags.
module socks5_client_reply_checker (
  input  logic              clk,
  input  logic              rst_n,
  scrc_in_if.sink           in_ch,
  scrc_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic              cfg_wdata
);

  // config
  logic auth_offered_r;

  // input register
  logic       in_vld_r;
  logic [1:0] in_cmd_r;
  logic [7:0] in_byte_r;
  logic [1:0] in_kind_r;

  // handshake state
  scrc_pkg::state_t  st_r;
  scrc_pkg::state_t  st_nxt;
  scrc_pkg::result_t res;

  // result register
  logic              out_vld_r;
  scrc_pkg::result_t out_r;

  logic out_free;
  logic adv;

  // result register can load when empty or being drained this cycle
  assign out_free    = !out_vld_r || out_ch.ready;
  assign adv         = in_vld_r && out_free;
  assign in_ch.ready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auth_offered_r <= 1'b0;
    end else if (cfg_we) begin
      auth_offered_r <= cfg_wdata;
    end
  end

  // input stage: capture the word on accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_cmd_r  <= in_ch.cmd;
      in_byte_r <= in_ch.rx_byte;
      in_kind_r <= in_ch.fault_kind;
    end
  end

  scrc_step u_step (
    .st           (st_r),
    .auth_offered (auth_offered_r),
    .cmd          (in_cmd_r),
    .rx_byte      (in_byte_r),
    .fault_kind   (in_kind_r),
    .st_nxt       (st_nxt),
    .res          (res)
  );

  // state moves only when the buffered word advances into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= scrc_pkg::STATE_RESET;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.status     = out_r.status;
  assign out_ch.error_code = out_r.error_code;
  assign out_ch.reply_code = out_r.reply_code;

`ifndef SYNTHESIS
  a_adv_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_vld_r)
    else $error("advanced word produced no result");

  a_fail_has_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.status == scrc_pkg::ST_FAIL |-> out_r.error_code != scrc_pkg::ERR_NONE)
    else $error("failed status without error code");

  a_reply_only_not_succ: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.reply_code != 8'd0 |-> out_r.error_code == scrc_pkg::ERR_NOT_SUCC)
    else $error("reply code set without not-succeeded error");

  a_idle_no_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == scrc_pkg::PH_IDLE |-> st_r.final_status == scrc_pkg::ST_WAIT &&
      st_r.final_error == scrc_pkg::ERR_NONE)
    else $error("idle phase carries an outcome");
`endif

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import scrc_pkg::*;

  // one word on the input channel
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] rx_byte;
    logic [1:0] fault_kind;
  } rx_word_t;

  localparam int RESULT_LATENCY = 1;     // result passes the input and result registers after acceptance
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving on any port and no register write
  localparam int PHASE_WORDS    = 360;   // at least this many random words per configuration phase

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  scrc_in_if  in_ch ();
  scrc_out_if out_ch ();

  socks5_client_reply_checker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // words waiting to be sent, and outcomes waiting to be seen
  rx_word_t rx_word_q[$];
  result_t  outcome_q[$];

  int unsigned n_queued;
  int unsigned n_errors;
  bit          quiet;      // no idling on either side
  int unsigned watchdog;

  // ---------------------------------------------------------------------------
  // Handshake tracker: its own copy of the block's state and register.
  // ---------------------------------------------------------------------------
  logic        auth_on;
  logic [2:0]  hs_phase;
  logic [1:0]  hs_idx;
  logic [7:0]  hs_skip;
  logic [23:0] hs_hold;    // earlier bytes of the current message, byte k at 8k
  logic [2:0]  hs_status;
  logic [3:0]  hs_error;

  // In the done phase every word repeats the final outcome; otherwise waiting.
  function automatic result_t echo_outcome();
    result_t r;
    r = '0;
    if (hs_phase == PH_DONE) begin
      r.status     = hs_status;
      r.error_code = hs_error;
      if (hs_error == ERR_NOT_SUCC)
        r.reply_code = hs_hold[15:8];
    end
    return r;
  endfunction

  function automatic result_t close_handshake(logic [2:0] st, logic [3:0] err);
    hs_phase  = PH_DONE;
    hs_status = st;
    hs_error  = err;
    return echo_outcome();
  endfunction

  function automatic result_t predict_outcome(rx_word_t w);
    result_t    r;
    logic [7:0] b;
    r = '0;
    b = w.rx_byte;
    case (w.cmd)
      CMD_START: begin
        // also a restart when a handshake is already under way
        hs_phase  = PH_METHOD;
        hs_idx    = '0;
        hs_skip   = '0;
        hs_hold   = '0;
        hs_status = ST_WAIT;
        hs_error  = ERR_NONE;
      end
      CMD_BYTE: begin
        case (hs_phase)
          PH_METHOD: begin
            if (hs_idx == 2'd0) begin
              hs_hold = {16'h0, b};
              hs_idx  = 2'd1;
            end else if (hs_hold[7:0] != SOCKS_VER) begin
              r = close_handshake(ST_FAIL, ERR_GREET_VER);
            end else if (b == METHOD_USERPW && auth_on) begin
              hs_phase = PH_AUTH;
              hs_idx   = '0;
              r.status = ST_AUTH;
            end else if (b == METHOD_NONE) begin
              hs_phase = PH_HEADER;
              hs_idx   = '0;
              r.status = ST_CONNECT;
            end else begin
              r = close_handshake(ST_FAIL, ERR_BAD_METHOD);
            end
          end
          PH_AUTH: begin
            if (hs_idx == 2'd0) begin
              hs_hold = {16'h0, b};
              hs_idx  = 2'd1;
            end else if (hs_hold[7:0] != AUTH_VER || b != AUTH_OK) begin
              r = close_handshake(ST_FAIL, ERR_AUTH_REJECT);
            end else begin
              hs_phase = PH_HEADER;
              hs_idx   = '0;
              r.status = ST_CONNECT;
            end
          end
          PH_HEADER: begin
            // VER, REP, RSV are held; ATYP arrives last and triggers the checks
            if (hs_idx < 2'd3) begin
              if (hs_idx == 2'd0)
                hs_hold = '0;
              hs_hold = hs_hold | ({16'h0, b} << (8 * hs_idx));
              hs_idx  = hs_idx + 2'd1;
            end else if (hs_hold[7:0] != SOCKS_VER) begin
              r = close_handshake(ST_FAIL, ERR_REPLY_VER);
            end else if (hs_hold[15:8] != REP_SUCCEEDED) begin
              r = close_handshake(ST_FAIL, ERR_NOT_SUCC);
            end else if (hs_hold[23:16] != '0) begin
              r = close_handshake(ST_FAIL, ERR_RSV_ATYP);
            end else if (b == ATYP_IPV4 || b == ATYP_IPV6) begin
              hs_phase = PH_ADDR;
              hs_idx   = '0;
              hs_skip  = (b == ATYP_IPV4) ? IPV4_LEN : IPV6_LEN;
            end else if (b == ATYP_DOMAIN) begin
              hs_phase = PH_DLEN;
              hs_idx   = '0;
            end else begin
              r = close_handshake(ST_FAIL, ERR_RSV_ATYP);
            end
          end
          PH_DLEN: begin
            // a zero length goes straight to the port bytes
            hs_skip  = b;
            hs_phase = (b == 8'd0) ? PH_PORT : PH_ADDR;
            hs_idx   = '0;
          end
          PH_ADDR: begin
            hs_skip = hs_skip - 8'd1;
            if (hs_skip == 8'd0) begin
              hs_phase = PH_PORT;
              hs_idx   = '0;
            end
          end
          PH_PORT: begin
            if (hs_idx == 2'd0)
              hs_idx = 2'd1;
            else
              r = close_handshake(ST_OK, ERR_NONE);
          end
          default: r = echo_outcome();
        endcase
      end
      CMD_FAULT: begin
        case (hs_phase)
          PH_METHOD: r = close_handshake(ST_FAIL, ERR_GREET_RX);
          PH_AUTH:   r = close_handshake(ST_FAIL, ERR_AUTH_RX);
          PH_HEADER: r = close_handshake(ST_FAIL, (w.fault_kind == FAULT_TIMEOUT) ?
                                                  ERR_REPLY_TMO : ERR_REPLY_RX);
          PH_DLEN, PH_ADDR, PH_PORT: r = close_handshake(ST_FAIL, ERR_ADDR_RX);
          default:   r = echo_outcome();
        endcase
      end
      default: r = echo_outcome();  // no-op word
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic rx_word_t make_word(logic [1:0] c, logic [7:0] b, logic [1:0] k);
    rx_word_t w;
    w.cmd        = c;
    w.rx_byte    = b;
    w.fault_kind = k;
    return w;
  endfunction

  // unused fields of a word are random so every bit toggles
  function automatic rx_word_t make_byte(logic [7:0] b);
    return make_word(CMD_BYTE, b, 2'($urandom));
  endfunction

  task automatic add_word(logic [1:0] c, logic [7:0] b, logic [1:0] k);
    rx_word_q.insert(rx_word_q.size(), make_word(c, b, k));
    n_queued++;
  endtask

  // One handshake as the proxy would answer it, with random content; a third
  // of them get damaged at one spot: bit flip, garbage byte, inserted fault,
  // start or no-op, or truncation (the next start then lands mid-handshake).
  task automatic queue_session();
    rx_word_t    seq[$];
    logic [7:0]  atyp;
    int unsigned n_addr;
    int unsigned pos;
    int unsigned pick;
    bit          userpw;
    seq.insert(seq.size(), make_word(CMD_START, 8'($urandom), 2'($urandom)));
    userpw = auth_on && ($urandom_range(0, 3) != 0);
    seq.insert(seq.size(), make_byte(SOCKS_VER));
    seq.insert(seq.size(), make_byte(userpw ? METHOD_USERPW : METHOD_NONE));
    if (userpw) begin
      seq.insert(seq.size(), make_byte(AUTH_VER));
      seq.insert(seq.size(), make_byte(AUTH_OK));
    end
    pick = $urandom_range(0, 2);
    atyp = (pick == 0) ? ATYP_IPV4 : (pick == 1) ? ATYP_IPV6 : ATYP_DOMAIN;
    seq.insert(seq.size(), make_byte(SOCKS_VER));
    seq.insert(seq.size(), make_byte(REP_SUCCEEDED));
    seq.insert(seq.size(), make_byte(8'h00));
    seq.insert(seq.size(), make_byte(atyp));
    if (atyp == ATYP_DOMAIN) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)
        n_addr = 255;
      else if (pick < 4)
        n_addr = 0;
      else
        n_addr = $urandom_range(1, 12);
      seq.insert(seq.size(), make_byte(8'(n_addr)));
    end else begin
      n_addr = (atyp == ATYP_IPV4) ? IPV4_LEN : IPV6_LEN;
    end
    repeat (n_addr) seq.insert(seq.size(), make_byte(8'($urandom)));
    repeat (2) seq.insert(seq.size(), make_byte(8'($urandom)));

    if ($urandom_range(0, 2) == 0) begin
      pos = $urandom_range(1, seq.size() - 1);
      case ($urandom_range(0, 5))
        0: seq[pos].rx_byte = seq[pos].rx_byte ^ (8'd1 << $urandom_range(0, 7));
        1: seq[pos].rx_byte = 8'($urandom);
        2: seq.insert(pos, make_word(CMD_FAULT, 8'($urandom), 2'($urandom)));
        3: seq.insert(pos, make_word(CMD_START, 8'($urandom), 2'($urandom)));
        4: seq.insert(pos, make_word(CMD_NOP, 8'($urandom), 2'($urandom)));
        default: while (seq.size() > pos) seq.pop_back();
      endcase
    end

    // a few words after the end of the handshake, now and then pure noise
    repeat ($urandom_range(0, 2))
      seq.insert(seq.size(),
                 make_word(2'($urandom_range(1, 3)), 8'($urandom), 2'($urandom)));
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 8))
        seq.insert(seq.size(), make_word(2'($urandom), 8'($urandom), 2'($urandom)));

    foreach (seq[i]) begin
      rx_word_q.insert(rx_word_q.size(), seq[i]);
      n_queued++;
    end
  endtask

  task automatic wait_drained();
    while (rx_word_q.size() != 0 || outcome_q.size() != 0) @(posedge clk);
  endtask

  // register write; only called while nothing is in flight
  task automatic write_auth(logic v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    auth_on    = v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: sends the head of rx_word_q, with random idle bursts. A word that
  // is offered stays put until it is taken.
  // ---------------------------------------------------------------------------
  int unsigned in_gap;
  int unsigned in_calm;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        outcome_q.insert(outcome_q.size(), predict_outcome(rx_word_q[0]));
        rx_word_q.delete(0);
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (!quiet && in_calm == 0 && $urandom_range(0, 5) == 0) begin
          in_gap = $urandom_range(0, 5);   // start an idle burst
          in_ch.valid <= 1'b0;
        end else if (rx_word_q.size() > 0) begin
          in_ch.valid      <= 1'b1;
          in_ch.cmd        <= rx_word_q[0].cmd;
          in_ch.rx_byte    <= rx_word_q[0].rx_byte;
          in_ch.fault_kind <= rx_word_q[0].fault_kind;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      // stretches with no idling at all
      if (in_calm > 0)
        in_calm--;
      else if ($urandom_range(0, 39) == 0)
        in_calm = $urandom_range(20, 80);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result word against the oldest outcome, and stalls
  // the result side in random bursts.
  // ---------------------------------------------------------------------------
  int unsigned out_gap;
  int unsigned out_calm;

  always @(posedge clk) begin
    result_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (outcome_q.size() == 0) begin
          $error("result word with nothing expected: status %0d error %0d reply %0d",
                 out_ch.status, out_ch.error_code, out_ch.reply_code);
          n_errors++;
        end else begin
          e = outcome_q.pop_front();
          if (out_ch.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_ch.status);
            n_errors++;
          end
          if (out_ch.error_code !== e.error_code) begin
            $error("error_code: expected %0d, got %0d", e.error_code, out_ch.error_code);
            n_errors++;
          end
          if (out_ch.reply_code !== e.reply_code) begin
            $error("reply_code: expected %0d, got %0d", e.reply_code, out_ch.reply_code);
            n_errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else if (!quiet && out_calm == 0 && $urandom_range(0, 5) == 0) begin
        out_gap = $urandom_range(0, 5);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
      if (out_calm > 0)
        out_calm--;
      else if ($urandom_range(0, 39) == 0)
        out_calm = $urandom_range(20, 80);
    end
  end

  // Watchdog: ends a hung run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
        watchdog = 0;
      else
        watchdog++;
      if (watchdog >= WATCHDOG_LIMIT) begin
        $display("** socks5_client_reply_checker: FAILED **");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence of the run
  // ---------------------------------------------------------------------------
  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.cmd        = CMD_NOP;
    in_ch.rx_byte    = '0;
    in_ch.fault_kind = '0;
    out_ch.ready     = 1'b0;
    n_queued         = 0;
    n_errors         = 0;
    quiet            = 1'b0;
    watchdog         = 0;
    in_gap           = 0;
    in_calm          = 0;
    out_gap          = 0;
    out_calm         = 0;
    // tracker after reset
    auth_on   = 1'b0;
    hs_phase  = PH_IDLE;
    hs_idx    = '0;
    hs_skip   = '0;
    hs_hold   = '0;
    hs_status = ST_WAIT;
    hs_error  = ERR_NONE;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed, auth not offered (reset value) ---
    // idle: bytes and faults are ignored
    add_word(CMD_BYTE,  8'hFF, 2'd3);
    add_word(CMD_FAULT, 8'h00, 2'd3);
    // bad version in the method reply, then its echo on a no-op
    add_word(CMD_START, 8'hFF, 2'd0);
    add_word(CMD_BYTE,  8'h04, 2'd2);
    add_word(CMD_BYTE,  METHOD_NONE, 2'd1);
    add_word(CMD_NOP,   8'hA5, 2'd1);
    // no-auth method, domain address of length zero, straight to the port
    add_word(CMD_START, 8'h00, 2'd3);
    add_word(CMD_BYTE,  SOCKS_VER, 2'd0);
    add_word(CMD_BYTE,  METHOD_NONE, 2'd3);
    add_word(CMD_BYTE,  SOCKS_VER, 2'd1);
    add_word(CMD_BYTE,  REP_SUCCEEDED, 2'd2);
    add_word(CMD_BYTE,  8'h00, 2'd0);
    add_word(CMD_BYTE,  ATYP_DOMAIN, 2'd3);
    add_word(CMD_BYTE,  8'h00, 2'd1);
    add_word(CMD_BYTE,  8'hFF, 2'd2);
    add_word(CMD_BYTE,  8'h00, 2'd0);
    // restart mid-handshake, then a timeout while the method reply is due
    add_word(CMD_START, 8'h5A, 2'd2);
    add_word(CMD_BYTE,  SOCKS_VER, 2'd1);
    add_word(CMD_START, 8'hA5, 2'd1);
    add_word(CMD_FAULT, 8'h5A, FAULT_TIMEOUT);
    wait_drained();

    // --- directed, auth offered ---
    write_auth(1'b1);
    add_word(CMD_START, 8'h00, 2'd0);
    add_word(CMD_BYTE,  SOCKS_VER, 2'd2);
    add_word(CMD_BYTE,  METHOD_USERPW, 2'd1);
    add_word(CMD_BYTE,  AUTH_VER, 2'd3);
    add_word(CMD_BYTE,  AUTH_OK, 2'd0);
    add_word(CMD_BYTE,  SOCKS_VER, 2'd2);
    add_word(CMD_FAULT, 8'hFF, FAULT_TIMEOUT);
    add_word(CMD_BYTE,  8'h33, 2'd1);
    wait_drained();

    // --- random handshakes over several register settings ---
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       write_auth(1'b0);
        1:       write_auth(1'b1);
        2:       write_auth(1'($urandom));
        default: write_auth(1'b1);
      endcase
      if (ph == 3)
        quiet = 1'b1;  // no idling in the closing stretch
      begin
        int unsigned target;
        target = n_queued + PHASE_WORDS;
        while (n_queued < target) queue_session();
      end
      wait_drained();
    end

    // let any stray result word show up
    repeat (RESULT_LATENCY + 3) @(posedge clk);
    if (n_errors == 0)
      $display("** socks5_client_reply_checker: PASSED **");
    else
      $display("** socks5_client_reply_checker: FAILED **");
    $finish;
  end

endmodule

// ===== socks5_client_reply_checker.f =====
design/scrc_pkg.sv
design/scrc_if.sv
design/scrc_step.sv
design/socks5_client_reply_checker.sv
test/testbench.sv
